// ----- design/rpu_pkg.sv -----
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared types and constants of the register-pair unit: memory size,
// action codes, pair codes, opcode patterns and instruction cycle counts.
// ----------------------------------------------------------------------------
package rpu_pkg;

   // byte memory size, a power of two between 256 and 65536
   localparam int MEM_DEPTH  = 65536;
   localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

   // what one input word asks for
   typedef enum logic [1:0] {
      ACT_EXEC  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // pair codes, as in bits 5..4 of an opcode and in pair_select
   localparam logic [2:0] PAIR_BC  = 3'd0;
   localparam logic [2:0] PAIR_DE  = 3'd1;
   localparam logic [2:0] PAIR_HL  = 3'd2;
   localparam logic [2:0] PAIR_SP  = 3'd3;
   localparam logic [2:0] PAIR_PSW = 3'd4;

   // opcode patterns
   localparam logic [7:0] PUSHPOP_MASK = 8'b11001011;
   localparam logic [7:0] PUSHPOP_PAT  = 8'b11000001;
   localparam logic [7:0] PUSH_BIT     = 8'b00000100;
   localparam logic [7:0] ARITH_MASK   = 8'b11001111;
   localparam logic [7:0] OP_DAD       = 8'b00001001;
   localparam logic [7:0] OP_INX       = 8'b00000011;
   localparam logic [7:0] OP_DCX       = 8'b00001011;
   localparam logic [7:0] OP_XCHG      = 8'b11101011;
   localparam logic [7:0] OP_XTHL      = 8'b11100011;
   localparam logic [7:0] OP_SPHL      = 8'b11111001;

   // machine cycles per instruction
   localparam logic [4:0] CYC_PUSH = 5'd11;
   localparam logic [4:0] CYC_POP  = 5'd10;
   localparam logic [4:0] CYC_DAD  = 5'd10;
   localparam logic [4:0] CYC_INC  = 5'd5;
   localparam logic [4:0] CYC_XCHG = 5'd4;
   localparam logic [4:0] CYC_XTHL = 5'd18;
   localparam logic [4:0] CYC_SPHL = 5'd5;
   localparam logic [4:0] CYC_NONE = 5'd0;

endpackage

// ----- design/rpu_ram.sv -----
// ----------------------------------------------------------------------------
// rpu_ram
// Generic single-port RAM with registered read data. The read data holds
// while the port is not enabled or is writing.
// ----------------------------------------------------------------------------
module rpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/cpu_register_pair_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_register_pair_unit
// Register-pair instructions of an 8-bit processor (push, pop, add to HL,
// increment, decrement, exchanges, SP load) on a kept register file, stack
// pointer and single-port byte memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  req_     in   req_valid / req_stall   action, opcode, pair, value, address, byte
//  rsp_     out  rsp_valid / rsp_stall   handled, cycles, five pairs, read byte
//
// A word moves through the engine in steps. Register-only work and memory
// writes finish in their first step; reads, PUSH, POP and XTHL take more, as
// the single memory port makes one byte access a cycle.
// The next word is taken at the edge the current one finishes.
// The result sits in an output register, so one stalled result does not
// block the engine; a second finished word waits in the engine.
// Reset clears the register pairs, the stack pointer and the busy and valid flags; memory is not cleared.
// ----------------------------------------------------------------------------
module cpu_register_pair_unit
   import rpu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_opcode,
   input  logic [2:0]  req_pair_select,
   input  logic [15:0] req_pair_value,
   input  logic [15:0] req_mem_address,
   input  logic [7:0]  req_mem_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_handled,
   output logic [4:0]  rsp_cycle_count,
   output logic [15:0] rsp_bc_value,
   output logic [15:0] rsp_de_value,
   output logic [15:0] rsp_hl_value,
   output logic [15:0] rsp_sp_value,
   output logic [15:0] rsp_psw_value,
   output logic [7:0]  rsp_read_byte
);

   typedef enum logic [2:0] {
      CLS_REG,
      CLS_WRITE,
      CLS_READ,
      CLS_PUSH,
      CLS_POP,
      CLS_XTHL
   } class_type;

   // held word
   logic        busy_ff;
   logic [1:0]  step_ff;
   action_type  act_ff;
   logic [7:0]  opc_ff;
   logic [2:0]  sel_ff;
   logic [15:0] val_ff;
   logic [15:0] addr_ff;
   logic [7:0]  byte_ff;

   // architectural state
   logic [15:0] bc_ff, de_ff, hl_ff, sp_ff, psw_ff;
   logic [15:0] bc_in, de_in, hl_in, sp_in, psw_in;

   // result register
   logic        rsp_valid_ff;
   logic        handled_ff, handled_in;
   logic [4:0]  cycles_ff, cycles_in;
   logic [7:0]  rd_ff, rd_in;

   // memory port
   logic                  ram_en;
   logic                  ram_we;
   logic [MEM_ADDR_W-1:0] ram_addr;
   logic [7:0]            ram_wdata;
   logic [7:0]            ram_rdata;

   class_type   cls;
   logic        last;
   logic        out_free;
   logic        advance;
   logic        finish;
   logic        req_take;
   logic [1:0]  code;
   logic [15:0] arith_val;
   logic [15:0] stack_val;
   logic [16:0] dad_sum;
   logic [15:0] sp_m1, sp_m2, sp_p1, sp_p2;

   rpu_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = busy_ff && (!last || out_free);
   assign finish    = busy_ff && last && out_free;
   assign req_stall = busy_ff && !finish;
   assign req_take  = req_valid && !req_stall;

   // decode the held word into a sequence class
   assign code = opc_ff[5:4];
   always_comb begin
      cls = CLS_REG;
      unique case (act_ff)
         ACT_WRITE: cls = CLS_WRITE;
         ACT_READ:  cls = CLS_READ;
         ACT_LOAD:  cls = CLS_REG;
         default: begin
            if ((opc_ff & PUSHPOP_MASK) == PUSHPOP_PAT) begin
               cls = ((opc_ff & PUSH_BIT) != 8'd0) ? CLS_PUSH : CLS_POP;
            end else if (opc_ff == OP_XTHL) begin
               cls = CLS_XTHL;
            end
         end
      endcase
   end

   // stack addresses and pair operands
   assign sp_m1 = sp_ff - 16'd1;
   assign sp_m2 = sp_ff - 16'd2;
   assign sp_p1 = sp_ff + 16'd1;
   assign sp_p2 = sp_ff + 16'd2;

   always_comb begin
      case (code)
         2'd0:    arith_val = bc_ff;
         2'd1:    arith_val = de_ff;
         2'd2:    arith_val = hl_ff;
         default: arith_val = sp_ff;
      endcase
      case (code)
         2'd0:    stack_val = bc_ff;
         2'd1:    stack_val = de_ff;
         2'd2:    stack_val = hl_ff;
         default: stack_val = psw_ff;
      endcase
   end

   assign dad_sum = {1'b0, hl_ff} + {1'b0, arith_val};

   // one step of the held word
   always_comb begin
      bc_in      = bc_ff;
      de_in      = de_ff;
      hl_in      = hl_ff;
      sp_in      = sp_ff;
      psw_in     = psw_ff;
      handled_in = 1'b1;
      cycles_in  = CYC_NONE;
      rd_in      = 8'd0;
      ram_en     = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = sp_ff[MEM_ADDR_W-1:0];
      ram_wdata  = 8'd0;
      last       = 1'b0;
      case (cls)
         CLS_WRITE: begin
            ram_en    = busy_ff;
            ram_we    = 1'b1;
            ram_addr  = addr_ff[MEM_ADDR_W-1:0];
            ram_wdata = byte_ff;
            last      = 1'b1;
         end
         CLS_READ: begin
            ram_addr = addr_ff[MEM_ADDR_W-1:0];
            if (step_ff == 2'd0) begin
               ram_en = busy_ff;
            end else begin
               rd_in = ram_rdata;
               last  = 1'b1;
            end
         end
         CLS_PUSH: begin
            ram_en    = busy_ff;
            ram_we    = 1'b1;
            cycles_in = CYC_PUSH;
            if (step_ff == 2'd0) begin
               ram_addr  = sp_m1[MEM_ADDR_W-1:0];
               ram_wdata = stack_val[15:8];
            end else begin
               ram_addr  = sp_m2[MEM_ADDR_W-1:0];
               ram_wdata = stack_val[7:0];
               sp_in     = sp_m2;
               last      = 1'b1;
            end
         end
         CLS_POP: begin
            cycles_in = CYC_POP;
            case (step_ff)
               2'd0: begin
                  ram_en = busy_ff;
               end
               2'd1: begin
                  ram_en   = busy_ff;
                  ram_addr = sp_p1[MEM_ADDR_W-1:0];
                  case (code)
                     2'd0:    bc_in[7:0]  = ram_rdata;
                     2'd1:    de_in[7:0]  = ram_rdata;
                     2'd2:    hl_in[7:0]  = ram_rdata;
                     default: psw_in[7:0] = ram_rdata;
                  endcase
               end
               default: begin
                  case (code)
                     2'd0:    bc_in[15:8]  = ram_rdata;
                     2'd1:    de_in[15:8]  = ram_rdata;
                     2'd2:    hl_in[15:8]  = ram_rdata;
                     default: psw_in[15:8] = ram_rdata;
                  endcase
                  sp_in = sp_p2;
                  last  = 1'b1;
               end
            endcase
         end
         CLS_XTHL: begin
            cycles_in = CYC_XTHL;
            ram_en    = busy_ff;
            case (step_ff)
               2'd0: begin
                  ram_we = 1'b0;
               end
               2'd1: begin
                  ram_we      = 1'b1;
                  ram_wdata   = hl_ff[7:0];
                  hl_in[7:0]  = ram_rdata;
               end
               2'd2: begin
                  ram_addr = sp_p1[MEM_ADDR_W-1:0];
               end
               default: begin
                  ram_we      = 1'b1;
                  ram_addr    = sp_p1[MEM_ADDR_W-1:0];
                  ram_wdata   = hl_ff[15:8];
                  hl_in[15:8] = ram_rdata;
                  last        = 1'b1;
               end
            endcase
         end
         default: begin
            // register-only work, done in one step
            last = 1'b1;
            if (act_ff == ACT_LOAD) begin
               case (sel_ff)
                  PAIR_BC:  bc_in  = val_ff;
                  PAIR_DE:  de_in  = val_ff;
                  PAIR_HL:  hl_in  = val_ff;
                  PAIR_SP:  sp_in  = val_ff;
                  PAIR_PSW: psw_in = val_ff;
                  default:  ;
               endcase
            end else if ((opc_ff & ARITH_MASK) == OP_DAD) begin
               hl_in     = dad_sum[15:0];
               psw_in[0] = dad_sum[16];
               cycles_in = CYC_DAD;
            end else if ((opc_ff & ARITH_MASK) == OP_INX ||
                         (opc_ff & ARITH_MASK) == OP_DCX) begin
               cycles_in = CYC_INC;
               case (code)
                  2'd0: bc_in = opc_ff[3] ? bc_ff - 16'd1 : bc_ff + 16'd1;
                  2'd1: de_in = opc_ff[3] ? de_ff - 16'd1 : de_ff + 16'd1;
                  2'd2: hl_in = opc_ff[3] ? hl_ff - 16'd1 : hl_ff + 16'd1;
                  default: sp_in = opc_ff[3] ? sp_ff - 16'd1 : sp_ff + 16'd1;
               endcase
            end else if (opc_ff == OP_XCHG) begin
               hl_in     = de_ff;
               de_in     = hl_ff;
               cycles_in = CYC_XCHG;
            end else if (opc_ff == OP_SPHL) begin
               sp_in     = hl_ff;
               cycles_in = CYC_SPHL;
            end else begin
               handled_in = 1'b0;
            end
         end
      endcase
   end

   // held word and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         if (req_take) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (finish) begin
            busy_ff <= 1'b0;
            step_ff <= 2'd0;
         end else if (advance) begin
            step_ff <= step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff  <= action_type'(req_action);
         opc_ff  <= req_opcode;
         sel_ff  <= req_pair_select;
         val_ff  <= req_pair_value;
         addr_ff <= req_mem_address;
         byte_ff <= req_mem_byte;
      end
   end

   // register pairs and stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff  <= 16'd0;
         de_ff  <= 16'd0;
         hl_ff  <= 16'd0;
         sp_ff  <= 16'd0;
         psw_ff <= 16'd0;
      end else if (advance) begin
         bc_ff  <= bc_in;
         de_ff  <= de_in;
         hl_ff  <= hl_in;
         sp_ff  <= sp_in;
         psw_ff <= psw_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic [15:0] r_bc_ff, r_de_ff, r_hl_ff, r_sp_ff, r_psw_ff;

   always_ff @(posedge clock) begin
      if (finish) begin
         handled_ff <= handled_in;
         cycles_ff  <= cycles_in;
         rd_ff      <= rd_in;
         r_bc_ff    <= bc_in;
         r_de_ff    <= de_in;
         r_hl_ff    <= hl_in;
         r_sp_ff    <= sp_in;
         r_psw_ff   <= psw_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_handled     = handled_ff;
   assign rsp_cycle_count = cycles_ff;
   assign rsp_bc_value    = r_bc_ff;
   assign rsp_de_value    = r_de_ff;
   assign rsp_hl_value    = r_hl_ff;
   assign rsp_sp_value    = r_sp_ff;
   assign rsp_psw_value   = r_psw_ff;
   assign rsp_read_byte   = rd_ff;

endmodule
